// ===== rtl/tdscr_pkg.sv =====
package tdscr_pkg;

	localparam int RAMP_STEPS_DEF = 15;
	localparam int POS_W          = 12;
	localparam int DLT_W          = 5;
	localparam logic [7:0] ANGLE_MAX   = 8'd180;
	localparam logic [6:0] MAX_VALUE   = 7'd99;
	localparam logic [3:0] DIGIT_MAX   = 4'd9;
	localparam logic [7:0] DIGIT_ANGLE = 8'd15;

	typedef enum logic [1:0] {
		CMD_INC = 2'd0,
		CMD_DEC = 2'd1,
		CMD_SET = 2'd2
	} cmd_t;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [DLT_W-1:0] dlt_t;

	function automatic logic [3:0] div10(input logic [6:0] v);
		logic [14:0] p;
		p = {8'd0, v} * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [7:0] clamp_angle(input pos_t a);
		if (a < 0) begin
			return 8'd0;
		end else if (a > $signed({{(POS_W-8){1'b0}}, ANGLE_MAX})) begin
			return ANGLE_MAX;
		end else begin
			return a[7:0];
		end
	endfunction

endpackage

// ===== rtl/two_digit_servo_counter_ramp.sv =====
// Two-digit servo counter ramp.
// s_tvalid/s_tready/s_tdata take command items: s_tdata[1:0] command
// (increment, decrement, set), s_tdata[9:2] target value for set.
// Each command that moves the counter yields RAMP_STEPS result items on
// m_tvalid/m_tready/m_tdata: m_tdata[7:0] tens angle, [15:8] ones angle;
// m_tlast marks the final step. Increment at 99, decrement at 0 and
// command 3 yield nothing.
// The command passes the holding register and the step generator before
// the first step is registered at the output. The step generator adds the
// digit differences once per step, one step per cycle unless m_tready is low.
// One decoded command waits in a holding register while a ramp runs, and
// the next ramp follows the previous one without a gap.
// cfg_we/cfg_index/cfg_data write the base angles (index 0 tens, 1 ones);
// write only while idle.
// Reset (arst_n low) clears the counter to zero, the base angles to 180
// and 0, and drops any pending items.
// When m_tready is low the current step holds and the generator stalls;
// s_tready falls once the holding register is full.
module two_digit_servo_counter_ramp #(
	parameter int RAMP_STEPS = tdscr_pkg::RAMP_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // command[1:0], target_value[9:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // tens_angle[7:0], ones_angle[15:8]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CNT_W = (RAMP_STEPS > 1) ? $clog2(RAMP_STEPS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RAMP_STEPS - 1);
	localparam int PW = tdscr_pkg::POS_W;

	logic [7:0] tens_base_q, ones_base_q;
	logic [3:0] tens_q, ones_q;

	logic             valid_s1;
	tdscr_pkg::pos_t  tp_s1, op_s1;
	tdscr_pkg::dlt_t  dt_s1, do_s1;

	logic             active_q;
	logic [CNT_W-1:0] cnt_q;
	tdscr_pkg::pos_t  tp_q, op_q;
	tdscr_pkg::dlt_t  dt_q, do_q;

	logic       out_valid_q, out_last_q;
	logic [7:0] out_tens_q, out_ones_q;

	logic [1:0] cmd;
	logic [7:0] tgt;
	logic       move;
	logic [3:0] nt, no;
	logic [6:0] sv;
	logic [3:0] sv_t;
	logic [7:0] sv_t10;
	logic       s_acc, out_load, fire, cnt_last, s1_take;
	tdscr_pkg::pos_t tp_next, op_next, tp_start, op_start;

	assign cmd   = s_tdata[1:0];
	assign tgt   = s_tdata[9:2];
	assign sv    = (tgt > {1'b0, tdscr_pkg::MAX_VALUE}) ? tdscr_pkg::MAX_VALUE : tgt[6:0];
	assign sv_t  = tdscr_pkg::div10(sv);
	assign sv_t10 = {1'b0, sv_t, 3'd0} + {3'd0, sv_t, 1'b0};

	always_comb begin
		move = 1'b0;
		nt   = tens_q;
		no   = ones_q;
		case (cmd)
			tdscr_pkg::CMD_INC: begin
				move = !(tens_q == tdscr_pkg::DIGIT_MAX && ones_q == tdscr_pkg::DIGIT_MAX);
				if (ones_q == tdscr_pkg::DIGIT_MAX) begin
					nt = tens_q + 4'd1;
					no = 4'd0;
				end else begin
					no = ones_q + 4'd1;
				end
			end
			tdscr_pkg::CMD_DEC: begin
				move = !(tens_q == 4'd0 && ones_q == 4'd0);
				if (ones_q == 4'd0) begin
					nt = tens_q - 4'd1;
					no = tdscr_pkg::DIGIT_MAX;
				end else begin
					no = ones_q - 4'd1;
				end
			end
			tdscr_pkg::CMD_SET: begin
				move = 1'b1;
				nt   = sv_t;
				no   = 4'(({1'b0, sv} - sv_t10));
			end
			default: begin
				move = 1'b0;
			end
		endcase
	end

	assign tp_start = $signed({{(PW-8){1'b0}}, tens_base_q})
	                - $signed(PW'(tdscr_pkg::DIGIT_ANGLE * {4'd0, tens_q}));
	assign op_start = $signed({{(PW-8){1'b0}}, ones_base_q})
	                + $signed(PW'(tdscr_pkg::DIGIT_ANGLE * {4'd0, ones_q}));

	assign out_load = !out_valid_q || m_tready;
	assign fire     = active_q && out_load;
	assign cnt_last = (cnt_q == CNT_LAST);
	assign s1_take  = valid_s1 && (!active_q || (fire && cnt_last));
	assign s_tready = !valid_s1 || s1_take;
	assign s_acc    = s_tvalid && s_tready;

	assign tp_next = tp_q + PW'(dt_q);
	assign op_next = op_q + PW'(do_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tens_base_q <= tdscr_pkg::ANGLE_MAX;
			ones_base_q <= 8'd0;
		end else if (cfg_we) begin
			if (cfg_index) begin
				ones_base_q <= cfg_data;
			end else begin
				tens_base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tens_q   <= 4'd0;
			ones_q   <= 4'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (s_acc && move) begin
				valid_s1 <= 1'b1;
				tens_q   <= nt;
				ones_q   <= no;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && move) begin
			tp_s1 <= tp_start;
			op_s1 <= op_start;
			dt_s1 <= tdscr_pkg::dlt_t'($signed({1'b0, tens_q}) - $signed({1'b0, nt}));
			do_s1 <= tdscr_pkg::dlt_t'($signed({1'b0, no}) - $signed({1'b0, ones_q}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (s1_take) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (fire) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			tp_q <= tp_s1;
			op_q <= op_s1;
			dt_q <= dt_s1;
			do_q <= do_s1;
		end else if (fire) begin
			tp_q <= tp_next;
			op_q <= op_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_tens_q <= tdscr_pkg::clamp_angle(tp_next);
			out_ones_q <= tdscr_pkg::clamp_angle(op_next);
			out_last_q <= cnt_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ones_q, out_tens_q};
	assign m_tlast  = out_last_q;

endmodule
